// File: sv/sli_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted list insert/delete core.
// No dependencies; compile first.
package sli_pkg;

  localparam int CAPACITY = 16;
  localparam int FILL_W   = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // Operation codes of the func field
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

  // Broadcast from the core to every cell
  typedef struct packed {
    logic                     ins;    // shift right from the insert point
    logic                     del;    // shift left from the match point
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

// File: sv/sli_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result of the sorted list core.
// Depends on sli_pkg.
interface sli_in_if;
  logic                                valid;
  logic                                ready;
  logic [sli_pkg::FUNC_W-1:0]          func;
  logic signed [sli_pkg::DATA_W-1:0]   value;
  logic [sli_pkg::INDEX_W-1:0]         index;

  modport source (output valid, func, value, index, input ready);
  modport sink   (input valid, func, value, index, output ready);
endinterface

interface sli_out_if;
  logic                                valid;
  logic                                ready;
  logic [sli_pkg::STATUS_W-1:0]        status;
  logic [sli_pkg::COUNT_W-1:0]         count;
  logic signed [sli_pkg::DATA_W-1:0]   smallest;
  logic signed [sli_pkg::DATA_W-1:0]   read_data;

  modport source (output valid, status, count, smallest, read_data, input ready);
  modport sink   (input valid, status, count, smallest, read_data, output ready);
endinterface

// File: sv/sli_cell.sv
`timescale 1ns / 1ps
// One position of the sorted list: holds an entry, compares it against the
// broadcast value and takes its neighbor's entry on a shift. Depends on sli_pkg.
module sli_cell (
  input  logic                              clk,
  input  sli_pkg::cell_ctl_t                ctl,
  input  logic                              valid,       // position below fill
  input  logic                              left_lt,     // left neighbor below value
  input  logic signed [sli_pkg::DATA_W-1:0] left_entry,
  input  logic signed [sli_pkg::DATA_W-1:0] right_entry,
  output logic                              lt,
  output logic                              eq,
  output logic signed [sli_pkg::DATA_W-1:0] entry,
  output logic signed [sli_pkg::DATA_W-1:0] entry_nxt
);

  logic signed [sli_pkg::DATA_W-1:0] entry_r;

  assign lt    = valid && (entry_r < ctl.value);
  assign eq    = valid && (entry_r == ctl.value);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && !lt) begin
      // first cell not below the value takes it, later ones shift right
      entry_nxt = left_lt ? ctl.value : left_entry;
    end else if (ctl.del && !lt) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: sv/sorted_list_insert_delete_core.sv
`timescale 1ns / 1ps
// Top level of the sorted list core: row of sli_cell positions, fill count
// and result register. Depends on sli_pkg, sli_if and sli_cell.
//
//  channel | dir | handshake          | payload
//  in_ch   | in  | valid/ready        | func, value, index
//  out_ch  | out | valid/ready        | status, count, smallest, read_data
//
// Every cell compares against the request value in parallel and shifts one
// position in the same cycle, so a new request is taken every cycle unless a
// result waits. The result is registered, valid in the cycle after acceptance.
// Reset clears the fill count and the result valid; entries stay unwritten.
// A stalled result holds in its register; in_ch.ready drops only while it waits.
module sorted_list_insert_delete_core (
  input  logic             clk,
  input  logic             rst_n,
  sli_in_if.sink           in_ch,
  sli_out_if.source        out_ch
);

  localparam int N = sli_pkg::CAPACITY;

  logic [sli_pkg::FILL_W-1:0]          fill_r, fill_nxt;
  logic                                out_valid_r;
  logic [sli_pkg::STATUS_W-1:0]        status_r, status_nxt;
  logic [sli_pkg::COUNT_W-1:0]         count_r;
  logic signed [sli_pkg::DATA_W-1:0]   smallest_r, smallest_nxt;
  logic signed [sli_pkg::DATA_W-1:0]   rdata_r, rdata_nxt;

  logic                                accept;
  logic                                full, empty, found, in_range;
  sli_pkg::cell_ctl_t                  ctl;

  logic [N-1:0]                        cell_valid, cell_lt, cell_eq;
  logic signed [sli_pkg::DATA_W-1:0]   cell_entry [N];
  logic signed [sli_pkg::DATA_W-1:0]   cell_nxt   [N];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign full     = (32'(fill_r) >= N);
  assign empty    = (fill_r == '0);
  assign found    = |cell_eq;
  assign in_range = (32'(in_ch.index) < 32'(fill_r));

  assign ctl.ins   = accept && (in_ch.func == sli_pkg::FUNC_INSERT) && !full;
  assign ctl.del   = accept && (in_ch.func == sli_pkg::FUNC_DELETE) && found;
  assign ctl.value = in_ch.value;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic                              l_lt;
      logic signed [sli_pkg::DATA_W-1:0] l_entry, r_entry;

      assign cell_valid[g] = (32'(g) < 32'(fill_r));

      if (g == 0) begin : g_first
        assign l_lt    = 1'b1;
        assign l_entry = in_ch.value;
      end else begin : g_mid
        assign l_lt    = cell_lt[g-1];
        assign l_entry = cell_entry[g-1];
      end

      if (g == N - 1) begin : g_last
        assign r_entry = cell_entry[g];
      end else begin : g_inner
        assign r_entry = cell_entry[g+1];
      end

      sli_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .valid       (cell_valid[g]),
        .left_lt     (l_lt),
        .left_entry  (l_entry),
        .right_entry (r_entry),
        .lt          (cell_lt[g]),
        .eq          (cell_eq[g]),
        .entry       (cell_entry[g]),
        .entry_nxt   (cell_nxt[g])
      );
    end
  endgenerate

  always_comb begin
    fill_nxt   = fill_r;
    status_nxt = sli_pkg::ST_OK;
    rdata_nxt  = '0;
    if (ctl.ins) begin
      fill_nxt = fill_r + 1'b1;
    end else if (ctl.del) begin
      fill_nxt = fill_r - 1'b1;
    end
    case (in_ch.func)
      sli_pkg::FUNC_INSERT: begin
        if (full) status_nxt = sli_pkg::ST_FULL;
      end
      sli_pkg::FUNC_DELETE: begin
        if (empty)       status_nxt = sli_pkg::ST_EMPTY;
        else if (!found) status_nxt = sli_pkg::ST_NOTFOUND;
      end
      sli_pkg::FUNC_READ: begin
        if (in_range) rdata_nxt  = cell_entry[sli_pkg::IDX_W'(in_ch.index)];
        else          status_nxt = sli_pkg::ST_RANGE;
      end
      default: begin
        status_nxt = sli_pkg::ST_OK;
      end
    endcase
    smallest_nxt = (fill_nxt != '0) ? cell_nxt[0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded only on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r   <= status_nxt;
      count_r    <= sli_pkg::COUNT_W'(fill_nxt);
      smallest_r <= smallest_nxt;
      rdata_r    <= rdata_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.count     = count_r;
  assign out_ch.smallest  = smallest_r;
  assign out_ch.read_data = rdata_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= N)
    else $error("fill count exceeds capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("insert did not grow the list by one");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.del |=> (fill_r == $past(fill_r) - 1'b1))
    else $error("delete did not shrink the list by one");

  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(fill_r) >= 2) |-> (cell_entry[0] <= cell_entry[1]))
    else $error("first two entries out of order");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");
`endif

endmodule

// File: test/sli_list_sb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the sorted list core: a shadow copy of the list that predicts
// every result, plus an in-order store of awaited results. Depends on sli_pkg.
package sli_list_sb_pkg;
  import sli_pkg::*;

  // func code with no operation behind it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] smallest;
    logic signed [DATA_W-1:0] read_data;
  } list_result_t;

  class list_scoreboard;
    logic signed [DATA_W-1:0] slots [CAPACITY];
    int                       used;
    list_result_t             awaited [$];
    int unsigned              errors;

    function new();
      used   = 0;
      errors = 0;
      foreach (slots[k]) slots[k] = '0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Apply one accepted request to the shadow list and queue its result.
    function void note_request(logic [FUNC_W-1:0] func, logic signed [DATA_W-1:0] value,
                               logic [INDEX_W-1:0] index);
      list_result_t res;
      int           pos;
      int           k;
      res = '0;
      res.status = ST_OK;
      case (func)
        FUNC_INSERT: begin
          if (used >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            // place ahead of any equal entries
            pos = 0;
            while (pos < used && slots[pos] < value) pos++;
            for (k = used; k > pos; k--) slots[k] = slots[k-1];
            slots[pos] = value;
            used++;
          end
        end
        FUNC_DELETE: begin
          if (used == 0) begin
            res.status = ST_EMPTY;
          end else begin
            pos = 0;
            while (pos < used && slots[pos] != value) pos++;
            if (pos >= used) begin
              res.status = ST_NOTFOUND;
            end else begin
              for (k = pos; k + 1 < used; k++) slots[k] = slots[k+1];
              used--;
            end
          end
        end
        FUNC_READ: begin
          if (int'(index) < used) res.read_data = slots[index];
          else res.status = ST_RANGE;
        end
        default: ;
      endcase
      res.count    = COUNT_W'(used);
      res.smallest = (used > 0) ? slots[0] : '0;
      awaited.push_back(res);
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected result st=%0d cnt=%0d min=%0d rd=%0d",
                       got.status, got.count, got.smallest, got.read_data));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.count !== want.count ||
          got.smallest !== want.smallest || got.read_data !== want.read_data)
        flag($sformatf("expected st=%0d cnt=%0d min=%0d rd=%0d, got st=%0d cnt=%0d min=%0d rd=%0d",
                       want.status, want.count, want.smallest, want.read_data,
                       got.status, got.count, got.smallest, got.read_data));
    endfunction
  endclass

endpackage

// File: test/sorted_list_insert_delete_core_test.sv
`timescale 1ns / 1ps
// Testbench for sorted_list_insert_delete_core: directed and random requests
// with random idling on both channels. Depends on sli_pkg, sli_if, sli_list_sb_pkg.
module sorted_list_insert_delete_core_test;
  import sli_pkg::*;
  import sli_list_sb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 900;
  localparam int HOLD_AT      = 300;
  localparam int DRAIN_AT     = 500;
  localparam int CALM_AT      = 750;
  localparam int LONG_HOLD    = 60;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic        clk;
  logic        rst_n;
  bit          calm;
  bit          hold_req;
  int unsigned cycle_count;

  sli_in_if  in_ch ();
  sli_out_if out_ch ();

  list_scoreboard sb = new();

  sorted_list_insert_delete_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one request, hold it until taken, then maybe idle for a burst.
  task automatic send_request(input logic [FUNC_W-1:0] func,
                              input logic signed [DATA_W-1:0] value,
                              input logic [INDEX_W-1:0] index);
    in_ch.valid <= 1'b1;
    in_ch.func  <= func;
    in_ch.value <= value;
    in_ch.index <= index;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && sb.used > 0) return sb.slots[$urandom_range(0, sb.used - 1)];
    if (r < 70) return DATA_W'($urandom_range(0, 30)) - 15;
    if (r < 92) return $urandom;
    case ($urandom_range(0, 3))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      default: return -1;
    endcase
  endfunction

  // Stimulus
  initial begin : stimulus
    int                  r;
    int                  ins_pct;
    int                  del_pct;
    logic [FUNC_W-1:0]   func;
    logic [INDEX_W-1:0]  index;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func  <= FUNC_INSERT;
    in_ch.value <= '0;
    in_ch.index <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list cases, extremes, duplicates, range and absent values
    send_request(FUNC_READ,   '0, 4'd0);
    send_request(FUNC_DELETE, 5, 4'd0);
    send_request(FUNC_UNUSED, VAL_MAX, 4'd15);
    send_request(FUNC_INSERT, VAL_MIN, 4'd0);
    send_request(FUNC_INSERT, VAL_MAX, 4'd15);
    send_request(FUNC_INSERT, '0, 4'd0);
    send_request(FUNC_INSERT, -1, 4'd0);
    send_request(FUNC_INSERT, '0, 4'd0);
    send_request(FUNC_READ,   '0, 4'd0);
    send_request(FUNC_READ,   '0, 4'd4);
    send_request(FUNC_READ,   '0, 4'd5);
    send_request(FUNC_READ,   '0, 4'd15);
    send_request(FUNC_UNUSED, -1, 4'd2);
    send_request(FUNC_DELETE, 7, 4'd0);
    send_request(FUNC_DELETE, VAL_MIN, 4'd0);
    send_request(FUNC_DELETE, VAL_MAX, 4'd0);
    send_request(FUNC_DELETE, '0, 4'd0);
    send_request(FUNC_DELETE, '0, 4'd0);
    // absent value against a single entry
    send_request(FUNC_DELETE, 7, 4'd0);
    send_request(FUNC_READ,   '0, 4'd0);
    send_request(FUNC_DELETE, -1, 4'd0);
    send_request(FUNC_DELETE, -1, 4'd0);

    // Random: alternate growing, shrinking and mixed stretches so the list
    // goes from empty to full and back
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == DRAIN_AT) wait_for_drain();
      if (i == CALM_AT) calm = 1'b1;
      case ((i / 50) % 3)
        0:       begin ins_pct = 65; del_pct = 12; end
        1:       begin ins_pct = 12; del_pct = 65; end
        default: begin ins_pct = 35; del_pct = 35; end
      endcase
      r = $urandom_range(0, 99);
      if (r < ins_pct) func = FUNC_INSERT;
      else if (r < ins_pct + del_pct) func = FUNC_DELETE;
      else if (r < 96) func = FUNC_READ;
      else func = FUNC_UNUSED;
      if ($urandom_range(0, 99) < 70 && sb.used > 0)
        index = INDEX_W'($urandom_range(0, sb.used - 1));
      else
        index = INDEX_W'($urandom_range(0, 15));
      send_request(func, pick_value(), index);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.pending() != 0) sb.flag("results still awaited at end of run");
    if (sb.errors == 0) begin
      $display("sorted_list_insert_delete_core_test: PASS");
    end else begin
      $display("sorted_list_insert_delete_core_test: FAIL");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm
  initial begin : receiver
    int stall;
    int hold_left;
    stall     = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 15) begin
        stall = $urandom_range(1, 10) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: note requests and check results as they are taken
  always @(posedge clk) begin
    list_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.func, in_ch.value, in_ch.index);
      if (out_ch.valid && out_ch.ready) begin
        got.status    = out_ch.status;
        got.count     = out_ch.count;
        got.smallest  = out_ch.smallest;
        got.read_data = out_ch.read_data;
        sb.check_result(got);
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("sorted_list_insert_delete_core_test: FAIL");
        $finish;
      end
    end
  end

endmodule

// File: files.f
sv/sli_pkg.sv
sv/sli_if.sv
sv/sli_cell.sv
sv/sorted_list_insert_delete_core.sv
test/sli_list_sb_pkg.sv
test/sorted_list_insert_delete_core_test.sv
